>>> sv/bwdi_pkg.sv
// bwdi_pkg: shared types, constants, fixed point helpers and the step sequence
// for the backwater depth integrator. Used by every module of the block.
`default_nettype none
package bwdi_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int CFG_W = 31;
    localparam int OUT_W = 31;
    localparam int PROD_W = 2 * DATA_W;
    localparam int DIV_STEPS = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int BIT_W = $clog2(DATA_W);
    localparam int PC_W = 6;
    localparam int OP_W = 4;
    localparam int SRC_W = 5;

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
    localparam q_t Q_ONE = q_t'(64'd1 << FRAC_W);
    localparam q_t Q_HALF = q_t'(64'd1 << (FRAC_W - 1));
    localparam q_t Q_G = q_t'(((64'd981 << FRAC_W) + 64'd50) / 64'd100);
    localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(1) << (DATA_W - 1);
    localparam logic [PROD_W-1:0] POS_LIM = NEG_LIM - PROD_W'(1);

    // step operations
    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV = 4'd3;
    localparam logic [OP_W-1:0] OP_CBRT = 4'd4;
    localparam logic [OP_W-1:0] OP_BRM1 = 4'd5;
    localparam logic [OP_W-1:0] OP_JMP = 4'd6;
    localparam logic [OP_W-1:0] OP_CHKDEN = 4'd7;
    localparam logic [OP_W-1:0] OP_END = 4'd8;

    // operand sources, the first ten are also write targets
    localparam logic [SRC_W-1:0] SRC_HP = 5'd0;
    localparam logic [SRC_W-1:0] SRC_DBED = 5'd1;
    localparam logic [SRC_W-1:0] SRC_H = 5'd2;
    localparam logic [SRC_W-1:0] SRC_FR2 = 5'd3;
    localparam logic [SRC_W-1:0] SRC_DEN = 5'd4;
    localparam logic [SRC_W-1:0] SRC_CF = 5'd5;
    localparam logic [SRC_W-1:0] SRC_T0 = 5'd6;
    localparam logic [SRC_W-1:0] SRC_T1 = 5'd7;
    localparam logic [SRC_W-1:0] SRC_FP = 5'd8;
    localparam logic [SRC_W-1:0] SRC_FC = 5'd9;
    localparam logic [SRC_W-1:0] SRC_ONE = 5'd10;
    localparam logic [SRC_W-1:0] SRC_G = 5'd11;
    localparam logic [SRC_W-1:0] SRC_HALF = 5'd12;
    localparam logic [SRC_W-1:0] SRC_QW = 5'd13;
    localparam logic [SRC_W-1:0] SRC_CZ = 5'd14;
    localparam logic [SRC_W-1:0] SRC_AL = 5'd15;
    localparam logic [SRC_W-1:0] SRC_KS = 5'd16;
    localparam logic [SRC_W-1:0] SRC_STEP = 5'd17;
    localparam logic [SRC_W-1:0] SRC_BED = 5'd18;
    localparam logic [SRC_W-1:0] SRC_LBED = 5'd19;
    localparam logic [SRC_W-1:0] SRC_LDEP = 5'd20;
    localparam logic [SRC_W-1:0] SRC_ZERO = 5'd21;

    localparam logic [1:0] FIN_NORM = 2'd0;
    localparam logic [1:0] FIN_BND = 2'd1;
    localparam logic [1:0] FIN_SING = 2'd2;

    localparam logic [PC_W-1:0] PC_SLOPE_A = 6'd3;
    localparam logic [PC_W-1:0] PC_SLOPE_B = 6'd24;
    localparam logic [PC_W-1:0] SLOPE_LEN = 6'd20;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SRC_W-1:0] src_a;
        logic [SRC_W-1:0] src_b;
        logic [SRC_W-1:0] dst;
        logic [PC_W-1:0]  tgt;
    } uop_t;

    typedef struct packed {
        logic [CFG_W-1:0] chezy;
        logic [CFG_W-1:0] step;
        logic [CFG_W-1:0] hmin;
        logic [CFG_W-1:0] qw;
        q_t               level;
        logic [CFG_W-1:0] ks;
        logic [CFG_W-1:0] alpha;
        logic             mode;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       start;
        uop_t       uop;
        logic       fin;
        logic [1:0] fin_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic den_nonpos;
    } dp_stat_t;

    function automatic logic [DATA_W-1:0] mag(input q_t v);
        logic [DATA_W-1:0] u;
        u = v;
        mag = u[DATA_W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic q_t from_mag(input logic [PROD_W-1:0] m, input logic neg);
        logic [DATA_W-1:0] t;
        t = ~m[DATA_W-1:0] + 1'b1;
        if (neg) begin
            from_mag = (m > NEG_LIM) ? Q_MIN : q_t'(t);
        end else begin
            from_mag = (m > POS_LIM) ? Q_MAX : q_t'(m[DATA_W-1:0]);
        end
    endfunction

    function automatic q_t q_scale(input logic [PROD_W-1:0] p, input logic neg);
        q_scale = from_mag(p >> FRAC_W, neg);
    endfunction

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_add = s[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
            sat_add = q_t'(s[DATA_W-1:0]);
        end
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_sub = s[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
            sat_sub = q_t'(s[DATA_W-1:0]);
        end
    endfunction

    function automatic uop_t mk(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] a,
                                input logic [SRC_W-1:0] b, input logic [SRC_W-1:0] d,
                                input logic [PC_W-1:0] t);
        mk = '{op: op, src_a: a, src_b: b, dst: d, tgt: t};
    endfunction

    // slope of the depth profile for the depth held in H, result into fdst
    function automatic uop_t slope_uop(input logic [PC_W-1:0] k, input logic [PC_W-1:0] base,
                                       input logic [SRC_W-1:0] fdst);
        logic [PC_W-1:0] to_mode1;
        logic [PC_W-1:0] to_tail;
        to_mode1 = base + 6'd10;
        to_tail = base + 6'd15;
        case (k)
            0: slope_uop = mk(OP_MUL, SRC_H, SRC_H, SRC_T0, '0);
            1: slope_uop = mk(OP_MUL, SRC_T0, SRC_H, SRC_T0, '0);
            2: slope_uop = mk(OP_MUL, SRC_G, SRC_T0, SRC_T0, '0);
            3: slope_uop = mk(OP_MUL, SRC_QW, SRC_QW, SRC_T1, '0);
            4: slope_uop = mk(OP_DIV, SRC_T1, SRC_T0, SRC_FR2, '0);
            5: slope_uop = mk(OP_SUB, SRC_ONE, SRC_FR2, SRC_DEN, '0);
            6: slope_uop = mk(OP_BRM1, SRC_ZERO, SRC_ZERO, SRC_T0, to_mode1);
            7: slope_uop = mk(OP_MUL, SRC_CZ, SRC_CZ, SRC_T0, '0);
            8: slope_uop = mk(OP_DIV, SRC_ONE, SRC_T0, SRC_CF, '0);
            9: slope_uop = mk(OP_JMP, SRC_ZERO, SRC_ZERO, SRC_T0, to_tail);
            10: slope_uop = mk(OP_MUL, SRC_AL, SRC_AL, SRC_T0, '0);
            11: slope_uop = mk(OP_DIV, SRC_ONE, SRC_T0, SRC_T1, '0);
            12: slope_uop = mk(OP_DIV, SRC_KS, SRC_H, SRC_T0, '0);
            13: slope_uop = mk(OP_CBRT, SRC_T0, SRC_ZERO, SRC_T0, '0);
            14: slope_uop = mk(OP_MUL, SRC_T1, SRC_T0, SRC_CF, '0);
            15: slope_uop = mk(OP_MUL, SRC_CF, SRC_FR2, SRC_T0, '0);
            16: slope_uop = mk(OP_MUL, SRC_T0, SRC_STEP, SRC_T0, '0);
            17: slope_uop = mk(OP_CHKDEN, SRC_ZERO, SRC_ZERO, SRC_T0, '0);
            18: slope_uop = mk(OP_SUB, SRC_DBED, SRC_T0, SRC_T0, '0);
            default: slope_uop = mk(OP_DIV, SRC_T0, SRC_DEN, fdst, '0);
        endcase
    endfunction

    function automatic uop_t rom_uop(input logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(OP_END, SRC_ZERO, SRC_ZERO, SRC_T0, '0);
        if (pc >= PC_SLOPE_A && pc < PC_SLOPE_A + SLOPE_LEN) begin
            u = slope_uop(pc - PC_SLOPE_A, PC_SLOPE_A, SRC_FP);
        end else if (pc >= PC_SLOPE_B && pc < PC_SLOPE_B + SLOPE_LEN) begin
            u = slope_uop(pc - PC_SLOPE_B, PC_SLOPE_B, SRC_FC);
        end else begin
            case (pc)
                0: u = mk(OP_ADD, SRC_LDEP, SRC_ZERO, SRC_HP, '0);
                1: u = mk(OP_SUB, SRC_BED, SRC_LBED, SRC_DBED, '0);
                2: u = mk(OP_ADD, SRC_HP, SRC_ZERO, SRC_H, '0);
                23: u = mk(OP_SUB, SRC_HP, SRC_FP, SRC_H, '0);
                44: u = mk(OP_ADD, SRC_FC, SRC_FP, SRC_T0, '0);
                45: u = mk(OP_MUL, SRC_T0, SRC_HALF, SRC_T0, '0);
                46: u = mk(OP_SUB, SRC_HP, SRC_T0, SRC_H, '0);
                default: u = mk(OP_END, SRC_ZERO, SRC_ZERO, SRC_T0, '0);
            endcase
        end
        rom_uop = u;
    endfunction

endpackage
`default_nettype wire

>>> sv/backwater_depth_integrator_top.sv
// backwater_depth_integrator_top: one item in, one item out, one item at a time.
// A boundary item goes straight to its result; an interior item runs the integration
// program, longer with Manning-Strickler friction than with Chezy friction, set by the
// bit-serial divider (48 quotient bits) and the cube root (square, cube, compare per bit).
// A finished item waits in the output register while the next one is taken.
// Synchronous active-low reset clears control, profile state and registers to defaults.
`default_nettype none
module backwater_depth_integrator_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [31:0]    s_bed_elevation,
    input  wire logic                  s_downstream_end,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [30:0]                m_depth,
    output logic                       m_clamped,
    output logic                       m_singular,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [4:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic [2:0] REG_CHEZY = 3'd0;
    localparam logic [2:0] REG_STEP = 3'd1;
    localparam logic [2:0] REG_HMIN = 3'd2;
    localparam logic [2:0] REG_QW = 3'd3;
    localparam logic [2:0] REG_LEVEL = 3'd4;
    localparam logic [2:0] REG_KS = 3'd5;
    localparam logic [2:0] REG_ALPHA = 3'd6;
    localparam logic [2:0] REG_MODE = 3'd7;

    bwdi_pkg::cfg_t     cfg_reg;
    bwdi_pkg::dp_cmd_t  cmd;
    bwdi_pkg::dp_stat_t stat;
    logic               wr_en;
    logic [2:0]         reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chezy <= 31'd1310720;
            cfg_reg.step <= 31'd65536;
            cfg_reg.hmin <= 31'd6554;
            cfg_reg.qw <= 31'd65536;
            cfg_reg.level <= '0;
            cfg_reg.ks <= 31'd6554;
            cfg_reg.alpha <= 31'd524288;
            cfg_reg.mode <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHEZY: cfg_reg.chezy <= pwdata[30:0];
                REG_STEP: cfg_reg.step <= pwdata[30:0];
                REG_HMIN: cfg_reg.hmin <= pwdata[30:0];
                REG_QW: cfg_reg.qw <= pwdata[30:0];
                REG_LEVEL: cfg_reg.level <= pwdata;
                REG_KS: cfg_reg.ks <= pwdata[30:0];
                REG_ALPHA: cfg_reg.alpha <= pwdata[30:0];
                default: cfg_reg.mode <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CHEZY: prdata = {1'b0, cfg_reg.chezy};
            REG_STEP: prdata = {1'b0, cfg_reg.step};
            REG_HMIN: prdata = {1'b0, cfg_reg.hmin};
            REG_QW: prdata = {1'b0, cfg_reg.qw};
            REG_LEVEL: prdata = cfg_reg.level;
            REG_KS: prdata = {1'b0, cfg_reg.ks};
            REG_ALPHA: prdata = {1'b0, cfg_reg.alpha};
            default: prdata = {31'd0, cfg_reg.mode};
        endcase
    end

    bwdi_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_downstream_end (s_downstream_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .mode             (cfg_reg.mode),
        .cmd              (cmd),
        .stat             (stat)
    );

    bwdi_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .stat            (stat),
        .s_bed_elevation (s_bed_elevation),
        .m_depth         (m_depth),
        .m_clamped       (m_clamped),
        .m_singular      (m_singular)
    );

endmodule
`default_nettype wire

>>> sv/bwdi_div.sv
// bwdi_div: saturating fixed point divider, one quotient bit per cycle.
// Depends on bwdi_pkg.
`default_nettype none
module bwdi_div (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  bwdi_pkg::q_t      a,
    input  bwdi_pkg::q_t      b,
    output logic              done,
    output bwdi_pkg::q_t      q
);

    logic                                   run_reg;
    logic                                   done_reg;
    logic [bwdi_pkg::DIV_CNT_W-1:0]         cnt_reg;
    logic [bwdi_pkg::DATA_W-1:0]            rem_reg;
    logic [bwdi_pkg::DIV_STEPS-1:0]         num_reg;
    logic [bwdi_pkg::DATA_W-1:0]            den_reg;
    logic                                   neg_reg;
    bwdi_pkg::q_t                           q_reg;
    logic [bwdi_pkg::DATA_W:0]              trial;
    logic [bwdi_pkg::DATA_W:0]              diff;
    logic                                   ge;

    assign trial = {rem_reg, num_reg[bwdi_pkg::DIV_STEPS-1]};
    assign ge = trial >= {1'b0, den_reg};
    assign diff = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= (start && (a == '0 || b == '0)) ||
                        (!start && run_reg && cnt_reg == '0);
            if (start) begin
                neg_reg <= a[bwdi_pkg::DATA_W-1] ^ b[bwdi_pkg::DATA_W-1];
                num_reg <= {bwdi_pkg::mag(a), {bwdi_pkg::FRAC_W{1'b0}}};
                den_reg <= bwdi_pkg::mag(b);
                rem_reg <= '0;
                if (a == '0) begin
                    q_reg <= '0;
                end else if (b == '0) begin
                    q_reg <= a[bwdi_pkg::DATA_W-1] ? bwdi_pkg::Q_MIN : bwdi_pkg::Q_MAX;
                end else begin
                    run_reg <= 1'b1;
                    cnt_reg <= bwdi_pkg::DIV_CNT_W'(bwdi_pkg::DIV_STEPS);
                end
            end else if (run_reg) begin
                if (cnt_reg == '0) begin
                    q_reg <= bwdi_pkg::from_mag(bwdi_pkg::PROD_W'(num_reg), neg_reg);
                    run_reg <= 1'b0;
                end else begin
                    rem_reg <= ge ? diff[bwdi_pkg::DATA_W-1:0] : trial[bwdi_pkg::DATA_W-1:0];
                    num_reg <= {num_reg[bwdi_pkg::DIV_STEPS-2:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q = q_reg;

endmodule
`default_nettype wire

>>> sv/bwdi_cbrt.sv
// bwdi_cbrt: fixed point cube root, one result bit per pass through its square, cube and compare phases.
// Depends on bwdi_pkg.
`default_nettype none
module bwdi_cbrt (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  bwdi_pkg::q_t      x,
    output logic              done,
    output bwdi_pkg::q_t      y
);

    localparam logic [1:0] PH_SQ = 2'd0;
    localparam logic [1:0] PH_CU = 2'd1;
    localparam logic [1:0] PH_CMP = 2'd2;

    logic                            run_reg;
    logic                            done_reg;
    logic [1:0]                      ph_reg;
    logic [bwdi_pkg::BIT_W-1:0]      bit_reg;
    logic [bwdi_pkg::DATA_W-1:0]     ax_reg;
    logic [bwdi_pkg::DATA_W-1:0]     y_reg;
    logic                            neg_reg;
    logic [bwdi_pkg::PROD_W-1:0]     p_reg;
    bwdi_pkg::q_t                    res_reg;
    logic [bwdi_pkg::DATA_W-1:0]     cand;
    logic [bwdi_pkg::DATA_W-1:0]     sq_u;
    logic [bwdi_pkg::PROD_W-1:0]     sq;
    logic [bwdi_pkg::PROD_W-1:0]     cu;
    logic [bwdi_pkg::DATA_W-1:0]     cube_u;
    logic [bwdi_pkg::DATA_W-1:0]     y_fin;
    logic [bwdi_pkg::DATA_W-1:0]     ax_next;

    assign cand = y_reg | (bwdi_pkg::DATA_W'(1) << bit_reg);
    assign sq = cand * cand;
    assign sq_u = bwdi_pkg::q_scale(p_reg, 1'b0);
    assign cu = sq_u * cand;
    assign cube_u = bwdi_pkg::q_scale(p_reg, 1'b0);
    assign y_fin = (cube_u <= ax_reg) ? cand : y_reg;
    assign ax_next = (x == bwdi_pkg::Q_MIN) ? bwdi_pkg::Q_MAX : bwdi_pkg::mag(x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg <= PH_SQ;
        end else begin
            done_reg <= !start && run_reg && (ph_reg == PH_CMP) && (bit_reg == '0);
            if (start) begin
                run_reg <= 1'b1;
                ph_reg <= PH_SQ;
                bit_reg <= bwdi_pkg::BIT_W'(bwdi_pkg::DATA_W - 2);
                y_reg <= '0;
                ax_reg <= ax_next;
                neg_reg <= x[bwdi_pkg::DATA_W-1];
            end else if (run_reg) begin
                unique case (ph_reg)
                    PH_SQ: begin
                        p_reg <= sq;
                        ph_reg <= PH_CU;
                    end
                    PH_CU: begin
                        p_reg <= cu;
                        ph_reg <= PH_CMP;
                    end
                    default: begin
                        y_reg <= y_fin;
                        ph_reg <= PH_SQ;
                        if (bit_reg == '0) begin
                            run_reg <= 1'b0;
                            res_reg <= neg_reg ? bwdi_pkg::q_t'(~y_fin + 1'b1)
                                               : bwdi_pkg::q_t'(y_fin);
                        end else begin
                            bit_reg <= bit_reg - 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign y = res_reg;

endmodule
`default_nettype wire

>>> sv/bwdi_datapath.sv
// bwdi_datapath: working registers, shared multiplier, divider and cube root,
// and the result and profile registers. Depends on bwdi_pkg, bwdi_div, bwdi_cbrt.
`default_nettype none
module bwdi_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  bwdi_pkg::cfg_t                        cfg,
    input  bwdi_pkg::dp_cmd_t                     cmd,
    output bwdi_pkg::dp_stat_t                    stat,
    input  wire logic signed [bwdi_pkg::DATA_W-1:0] s_bed_elevation,
    output logic [bwdi_pkg::OUT_W-1:0]            m_depth,
    output logic                                  m_clamped,
    output logic                                  m_singular
);

    localparam logic [1:0] EX_IDLE = 2'd0;
    localparam logic [1:0] EX_GO = 2'd1;
    localparam logic [1:0] EX_MUL = 2'd2;
    localparam logic [1:0] EX_WAIT = 2'd3;

    bwdi_pkg::q_t hp_reg, dbed_reg, h_reg, fr2_reg, den_reg;
    bwdi_pkg::q_t cf_reg, t0_reg, t1_reg, fp_reg, fc_reg;
    bwdi_pkg::q_t bed_reg, last_bed_reg;
    logic [bwdi_pkg::OUT_W-1:0]     last_depth_reg;
    bwdi_pkg::q_t                   opa_reg, opb_reg;
    logic [bwdi_pkg::OP_W-1:0]      op_reg;
    logic [bwdi_pkg::SRC_W-1:0]     dst_reg;
    logic [1:0]                     ex_reg, ex_next;
    logic [bwdi_pkg::PROD_W-1:0]    prod_reg;
    logic                           pneg_reg;
    logic [bwdi_pkg::OUT_W-1:0]     depth_reg;
    logic                           clamped_reg, singular_reg;

    logic [bwdi_pkg::PROD_W-1:0]    prod_full;
    logic                           wr_en;
    bwdi_pkg::q_t                   wr_val;
    logic                           div_start, div_done, cbrt_start, cbrt_done;
    bwdi_pkg::q_t                   div_q, cbrt_y, src_a, src_b, bnd, hmin_q;
    logic [bwdi_pkg::OUT_W-1:0]     fin_depth;
    logic                           fin_clamped, fin_singular;

    function automatic bwdi_pkg::q_t pick(input logic [bwdi_pkg::SRC_W-1:0] s);
        unique case (s)
            bwdi_pkg::SRC_HP: pick = hp_reg;
            bwdi_pkg::SRC_DBED: pick = dbed_reg;
            bwdi_pkg::SRC_H: pick = h_reg;
            bwdi_pkg::SRC_FR2: pick = fr2_reg;
            bwdi_pkg::SRC_DEN: pick = den_reg;
            bwdi_pkg::SRC_CF: pick = cf_reg;
            bwdi_pkg::SRC_T0: pick = t0_reg;
            bwdi_pkg::SRC_T1: pick = t1_reg;
            bwdi_pkg::SRC_FP: pick = fp_reg;
            bwdi_pkg::SRC_FC: pick = fc_reg;
            bwdi_pkg::SRC_ONE: pick = bwdi_pkg::Q_ONE;
            bwdi_pkg::SRC_G: pick = bwdi_pkg::Q_G;
            bwdi_pkg::SRC_HALF: pick = bwdi_pkg::Q_HALF;
            bwdi_pkg::SRC_QW: pick = bwdi_pkg::q_t'({1'b0, cfg.qw});
            bwdi_pkg::SRC_CZ: pick = bwdi_pkg::q_t'({1'b0, cfg.chezy});
            bwdi_pkg::SRC_AL: pick = bwdi_pkg::q_t'({1'b0, cfg.alpha});
            bwdi_pkg::SRC_KS: pick = bwdi_pkg::q_t'({1'b0, cfg.ks});
            bwdi_pkg::SRC_STEP: pick = bwdi_pkg::q_t'({1'b0, cfg.step});
            bwdi_pkg::SRC_BED: pick = bed_reg;
            bwdi_pkg::SRC_LBED: pick = last_bed_reg;
            bwdi_pkg::SRC_LDEP: pick = bwdi_pkg::q_t'({1'b0, last_depth_reg});
            default: pick = '0;
        endcase
    endfunction

    assign src_a = pick(cmd.uop.src_a);
    assign src_b = pick(cmd.uop.src_b);
    assign prod_full = bwdi_pkg::mag(opa_reg) * bwdi_pkg::mag(opb_reg);

    bwdi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (opa_reg),
        .b       (opb_reg),
        .done    (div_done),
        .q       (div_q)
    );

    bwdi_cbrt u_cbrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cbrt_start),
        .x       (opa_reg),
        .done    (cbrt_done),
        .y       (cbrt_y)
    );

    always_comb begin
        ex_next = ex_reg;
        wr_en = 1'b0;
        wr_val = opa_reg;
        div_start = 1'b0;
        cbrt_start = 1'b0;
        case (ex_reg)
            EX_GO: begin
                case (op_reg)
                    bwdi_pkg::OP_ADD: begin
                        wr_en = 1'b1;
                        wr_val = bwdi_pkg::sat_add(opa_reg, opb_reg);
                        ex_next = EX_IDLE;
                    end
                    bwdi_pkg::OP_SUB: begin
                        wr_en = 1'b1;
                        wr_val = bwdi_pkg::sat_sub(opa_reg, opb_reg);
                        ex_next = EX_IDLE;
                    end
                    bwdi_pkg::OP_MUL: ex_next = EX_MUL;
                    bwdi_pkg::OP_DIV: begin
                        div_start = 1'b1;
                        ex_next = EX_WAIT;
                    end
                    bwdi_pkg::OP_CBRT: begin
                        cbrt_start = 1'b1;
                        ex_next = EX_WAIT;
                    end
                    default: ex_next = EX_IDLE;
                endcase
            end
            EX_MUL: begin
                wr_en = 1'b1;
                wr_val = bwdi_pkg::q_scale(prod_reg, pneg_reg);
                ex_next = EX_IDLE;
            end
            EX_WAIT: begin
                if (op_reg == bwdi_pkg::OP_DIV) begin
                    wr_en = div_done;
                    wr_val = div_q;
                end else begin
                    wr_en = cbrt_done;
                    wr_val = cbrt_y;
                end
                if (wr_en) begin
                    ex_next = EX_IDLE;
                end
            end
            default: begin
                if (cmd.start) begin
                    ex_next = EX_GO;
                end
            end
        endcase
    end

    assign hmin_q = bwdi_pkg::q_t'({1'b0, cfg.hmin});
    assign bnd = bwdi_pkg::sat_sub(cfg.level, bed_reg);

    always_comb begin
        fin_clamped = 1'b0;
        fin_singular = 1'b0;
        fin_depth = h_reg[bwdi_pkg::OUT_W-1:0];
        unique case (cmd.fin_kind)
            bwdi_pkg::FIN_BND: begin
                fin_depth = bnd[bwdi_pkg::DATA_W-1] ? '0 : bnd[bwdi_pkg::OUT_W-1:0];
            end
            bwdi_pkg::FIN_SING: begin
                fin_depth = '1;
                fin_singular = 1'b1;
            end
            default: begin
                if (h_reg < hmin_q) begin
                    fin_depth = cfg.hmin;
                    fin_clamped = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_reg <= EX_IDLE;
            last_depth_reg <= '0;
            last_bed_reg <= '0;
        end else begin
            ex_reg <= ex_next;
            if (cmd.fin) begin
                last_depth_reg <= fin_depth;
                last_bed_reg <= bed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bed_reg <= s_bed_elevation;
        end
        if (cmd.start) begin
            opa_reg <= src_a;
            opb_reg <= src_b;
            op_reg <= cmd.uop.op;
            dst_reg <= cmd.uop.dst;
        end
        if (ex_reg == EX_GO) begin
            prod_reg <= prod_full;
            pneg_reg <= opa_reg[bwdi_pkg::DATA_W-1] ^ opb_reg[bwdi_pkg::DATA_W-1];
        end
        if (cmd.fin) begin
            depth_reg <= fin_depth;
            clamped_reg <= fin_clamped;
            singular_reg <= fin_singular;
        end
        if (wr_en) begin
            case (dst_reg)
                bwdi_pkg::SRC_HP: hp_reg <= wr_val;
                bwdi_pkg::SRC_DBED: dbed_reg <= wr_val;
                bwdi_pkg::SRC_H: h_reg <= wr_val;
                bwdi_pkg::SRC_FR2: fr2_reg <= wr_val;
                bwdi_pkg::SRC_DEN: den_reg <= wr_val;
                bwdi_pkg::SRC_CF: cf_reg <= wr_val;
                bwdi_pkg::SRC_T0: t0_reg <= wr_val;
                bwdi_pkg::SRC_T1: t1_reg <= wr_val;
                bwdi_pkg::SRC_FP: fp_reg <= wr_val;
                bwdi_pkg::SRC_FC: fc_reg <= wr_val;
                default: ;
            endcase
        end
    end

    assign stat.done = wr_en;
    assign stat.den_nonpos = den_reg[bwdi_pkg::DATA_W-1] || (den_reg == '0);
    assign m_depth = depth_reg;
    assign m_clamped = clamped_reg;
    assign m_singular = singular_reg;

endmodule
`default_nettype wire

>>> sv/bwdi_ctrl.sv
// bwdi_ctrl: sequencer that steps through the integration program and runs
// the item handshakes. Depends on bwdi_pkg.
`default_nettype none
module bwdi_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_downstream_end,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire logic           mode,
    output bwdi_pkg::dp_cmd_t   cmd,
    input  bwdi_pkg::dp_stat_t  stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_FIN = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [bwdi_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [1:0]                  kind_reg, kind_next;
    logic                        m_valid_reg, m_valid_next;
    bwdi_pkg::uop_t              uop;

    assign uop = bwdi_pkg::rom_uop(pc_reg);

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg;
        kind_next = kind_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        cmd.uop = uop;
        cmd.fin_kind = kind_reg;
        s_ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_downstream_end) begin
                        kind_next = bwdi_pkg::FIN_BND;
                        state_next = ST_FIN;
                    end else begin
                        pc_next = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                unique case (uop.op) inside
                    bwdi_pkg::OP_ADD, bwdi_pkg::OP_SUB, bwdi_pkg::OP_MUL,
                    bwdi_pkg::OP_DIV, bwdi_pkg::OP_CBRT: begin
                        cmd.start = 1'b1;
                        state_next = ST_WAIT;
                    end
                    bwdi_pkg::OP_BRM1: pc_next = mode ? uop.tgt : pc_reg + 1'b1;
                    bwdi_pkg::OP_JMP: pc_next = uop.tgt;
                    bwdi_pkg::OP_CHKDEN: begin
                        if (stat.den_nonpos) begin
                            kind_next = bwdi_pkg::FIN_SING;
                            state_next = ST_FIN;
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    default: begin
                        kind_next = bwdi_pkg::FIN_NORM;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_WAIT: begin
                if (stat.done) begin
                    pc_next = pc_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            default: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.fin = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            kind_reg <= bwdi_pkg::FIN_NORM;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            kind_reg <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for backwater_depth_integrator_top.
// Drives bed elevations through the valid/ready input channel, programs the APB registers
// and checks every depth result against a fixed point Heun integrator kept here.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam longint DMAX = 64'sh7FFF_FFFF;
    localparam longint DMIN = -64'sh8000_0000;
    localparam longint QONE = 64'sd65536;
    localparam longint QHALF = 64'sd32768;
    localparam longint GRAV = ((64'sd981 <<< 16) + 64'sd50) / 64'sd100;
    localparam int WATCHDOG_LIMIT = 40000;

    localparam logic [4:0] REG_CHEZY = 5'd0;
    localparam logic [4:0] REG_STEP = 5'd4;
    localparam logic [4:0] REG_HMIN = 5'd8;
    localparam logic [4:0] REG_QW = 5'd12;
    localparam logic [4:0] REG_LEVEL = 5'd16;
    localparam logic [4:0] REG_KS = 5'd20;
    localparam logic [4:0] REG_ALPHA = 5'd24;
    localparam logic [4:0] REG_MODE = 5'd28;

    typedef struct packed {
        logic signed [31:0] bed;
        logic               boundary;
    } node_t;

    typedef struct packed {
        logic [30:0] depth;
        logic        clamped;
        logic        singular;
    } depth_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_bed_elevation = '0;
    logic s_downstream_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [30:0] m_depth;
    logic m_clamped;
    logic m_singular;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    node_t pending_nodes[$];
    depth_t expected_depths[$];
    int errors = 0;
    int nodes_sent = 0;
    int quiet_cycles = 0;

    // mirror of the register file
    longint cz_q = 1310720, step_q = 65536, hmin_q = 6554, qw_q = 65536;
    longint level_q = 0, ks_q = 6554, alpha_q = 524288;
    bit mode_q = 1'b0;
    // profile state
    longint prev_depth = 0, prev_bed = 0;

    backwater_depth_integrator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_bed_elevation(s_bed_elevation), .s_downstream_end(s_downstream_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_depth(m_depth), .m_clamped(m_clamped), .m_singular(m_singular),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint clip(input longint v);
        return v > DMAX ? DMAX : (v < DMIN ? DMIN : v);
    endfunction

    function automatic longint signed_mag(input longint m, input bit neg);
        if (neg) return m > -DMIN ? DMIN : -m;
        return m > DMAX ? DMAX : m;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        return signed_mag((ma * mb) >>> 16, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(input longint a, input longint b);
        longint ma, mb;
        if (a == 0) return 0;
        if (b == 0) return a < 0 ? DMIN : DMAX;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        return signed_mag((ma <<< 16) / mb, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_cube(input longint x);
        return fx_mul(fx_mul(x, x), x);
    endfunction

    function automatic longint fx_cbrt(input longint x);
        longint ax, y, c;
        ax = x < 0 ? (x == DMIN ? DMAX : -x) : x;
        y = 0;
        for (int b = 30; b >= 0; b--) begin
            c = y | (64'sd1 <<< b);
            if (fx_cube(c) <= ax) y = c;
        end
        return x < 0 ? -y : y;
    endfunction

    function automatic longint froude_sq(input longint h);
        return fx_div(fx_mul(qw_q, qw_q), fx_mul(GRAV, fx_cube(h)));
    endfunction

    function automatic longint friction_coef(input longint h);
        if (!mode_q) return fx_div(QONE, fx_mul(cz_q, cz_q));
        return fx_mul(fx_div(QONE, fx_mul(alpha_q, alpha_q)), fx_cbrt(fx_div(ks_q, h)));
    endfunction

    function automatic bit surface_slope(input longint h, input longint dbed,
                                         output longint f);
        longint fr2, den, s;
        fr2 = froude_sq(h);
        den = clip(QONE - fr2);
        s = fx_mul(fx_mul(friction_coef(h), fr2), step_q);
        f = 0;
        if (den <= 0) return 1'b0;
        f = fx_div(clip(dbed - s), den);
        return 1'b1;
    endfunction

    function automatic depth_t integrate_node(input node_t n);
        depth_t r;
        longint bed, h, dbed, fp, fc;
        bed = longint'(n.bed);
        r.clamped = 1'b0;
        r.singular = 1'b0;
        if (n.boundary) begin
            h = clip(level_q - bed);
            if (h < 0) h = 0;
        end else begin
            dbed = clip(bed - prev_bed);
            if (!surface_slope(prev_depth, dbed, fp) ||
                    !surface_slope(clip(prev_depth - fp), dbed, fc)) begin
                h = DMAX;
                r.singular = 1'b1;
            end else begin
                h = clip(prev_depth - fx_mul(clip(fc + fp), QHALF));
                if (h < hmin_q) begin
                    h = hmin_q;
                    r.clamped = 1'b1;
                end
                if (h < 0) h = 0;
            end
        end
        prev_depth = h;
        prev_bed = bed;
        r.depth = h[30:0];
        return r;
    endfunction

    // input channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_depths.push_back(integrate_node('{s_bed_elevation, s_downstream_end}));
                nodes_sent <= nodes_sent + 1;
            end
            if (pending_nodes.size() != 0 &&
                    ((nodes_sent > 900 && nodes_sent < 1150) || $urandom_range(99) >= 19)) begin
                node_t n;
                n = pending_nodes.pop_front();
                s_valid <= 1'b1;
                s_bed_elevation <= n.bed;
                s_downstream_end <= n.boundary;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_depths.size() == 0) begin
                    $display("%0t: unexpected result depth=%0d", $time, m_depth);
                    errors++;
                end else begin
                    depth_t e;
                    e = expected_depths.pop_front();
                    if (m_depth !== e.depth)
                        $display("%0t: depth expected %0d actual %0d", $time, e.depth, m_depth);
                    if (m_clamped !== e.clamped)
                        $display("%0t: clamped expected %0b actual %0b", $time, e.clamped,
                                 m_clamped);
                    if (m_singular !== e.singular)
                        $display("%0t: singular expected %0b actual %0b", $time, e.singular,
                                 m_singular);
                    if (m_depth !== e.depth || m_clamped !== e.clamped ||
                            m_singular !== e.singular)
                        errors++;
                end
            end
            m_ready <= (nodes_sent > 900 && nodes_sent < 1150) || $urandom_range(99) >= 19;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[backwater_depth_integrator_top] ERROR");
            $finish;
        end
    end

    task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_config(input longint cz, input longint stp, input longint hmin,
                               input longint qw, input longint lvl, input longint ks,
                               input longint al, input bit md);
        apb_write(REG_CHEZY, 32'(cz));
        apb_write(REG_STEP, 32'(stp));
        apb_write(REG_HMIN, 32'(hmin));
        apb_write(REG_QW, 32'(qw));
        apb_write(REG_LEVEL, 32'(lvl));
        apb_write(REG_KS, 32'(ks));
        apb_write(REG_ALPHA, 32'(al));
        apb_write(REG_MODE, {31'd0, md});
        cz_q = cz & 64'h7FFF_FFFF;
        step_q = stp & 64'h7FFF_FFFF;
        hmin_q = hmin & 64'h7FFF_FFFF;
        qw_q = qw & 64'h7FFF_FFFF;
        level_q = longint'(signed'(32'(lvl)));
        ks_q = ks & 64'h7FFF_FFFF;
        alpha_q = al & 64'h7FFF_FFFF;
        mode_q = md;
    endtask

    task automatic drain;
        while (pending_nodes.size() != 0 || expected_depths.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic add_node(input longint bed, input bit boundary);
        pending_nodes.push_back('{32'(bed), boundary});
    endtask

    // a boundary node then a run of interior nodes with a mild bed slope
    task automatic add_profile(input int count);
        longint bed, slope;
        bed = clip(level_q - longint'($urandom_range(200000, 6000)));
        slope = longint'($urandom_range(4000)) - 1000;
        add_node(bed, 1'b1);
        for (int i = 1; i < count; i++) begin
            bed = clip(bed + slope + longint'($urandom_range(1000)) - 500);
            add_node(bed, 1'b0);
        end
    endtask

    initial begin
        int left;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default settings, corner nodes
        add_node(-65536, 1'b0);
        add_node(DMIN, 1'b1);
        add_node(0, 1'b0);
        add_node(DMAX, 1'b1);
        add_node(0, 1'b0);
        add_node(-65536, 1'b1);
        add_node(-64000, 1'b0);
        add_node(-62000, 1'b0);
        add_node(-60000, 1'b0);
        add_node(-6000000, 1'b0);
        add_node(-65536, 1'b1);
        add_node(DMAX, 1'b0);
        add_node(-131072, 1'b1);
        add_node(DMIN, 1'b0);
        add_node(-200000, 1'b1);
        add_node(-199000, 1'b0);
        add_node(-198000, 1'b0);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 1)
                load_config(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1);
            else if (p == 2)
                load_config(0, 0, 0, 0, DMIN, 0, 1, 1'b0);
            else
                load_config($urandom_range(2000000, 100000), $urandom_range(6553600, 1000),
                            $urandom_range(20000), $urandom_range(600000, 10000),
                            longint'(signed'(32'($urandom))) >>> 4,
                            $urandom_range(100000), $urandom_range(1000000, 65536), p[0]);
            left = 250;
            while (left > 0) begin
                if ($urandom_range(9) == 0) begin
                    add_node(longint'(signed'(32'($urandom))), 1'($urandom));
                    left--;
                end else begin
                    int n;
                    n = $urandom_range(20, 1);
                    if (n > left) n = left;
                    add_profile(n);
                    left -= n;
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("[backwater_depth_integrator_top] OK");
        end else begin
            $display("[backwater_depth_integrator_top] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
sv/bwdi_pkg.sv
sv/bwdi_div.sv
sv/bwdi_cbrt.sv
sv/bwdi_datapath.sv
sv/bwdi_ctrl.sv
sv/backwater_depth_integrator_top.sv
tb/tb_top.sv
